// ----- rtl/u16u8_pkg.sv -----
// Shared types, constants and UTF-8 byte helpers for the UTF-16LE to UTF-8 transcoder.
// No dependencies; the front end, queue, back end and top import this package.
package u16u8_pkg;

   localparam int unsigned CP_W = 21;

   localparam logic [15:0] SUR_HIGH_MIN = 16'hD800;
   localparam logic [15:0] SUR_HIGH_MAX = 16'hDBFF;
   localparam logic [15:0] SUR_LOW_MIN  = 16'hDC00;
   localparam logic [15:0] SUR_LOW_MAX  = 16'hDFFF;
   localparam logic [15:0] BOM_UNIT     = 16'hFEFF;
   localparam logic [5:0]  SUR_HIGH_TAG = 6'b110110;

   localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
   localparam logic [CP_W-1:0] ONE_MAX   = 21'h7F;
   localparam logic [CP_W-1:0] TWO_MAX   = 21'h7FF;
   localparam logic [CP_W-1:0] THREE_MAX = 21'hFFFF;

   localparam logic [7:0] LEAD2 = 8'hC0;
   localparam logic [7:0] LEAD3 = 8'hE0;
   localparam logic [7:0] LEAD4 = 8'hF0;
   localparam logic [7:0] CONT  = 8'h80;

   typedef logic [CP_W-1:0] cp_type;
   // Index of a byte within one UTF-8 sequence, also used for the index of its last byte.
   typedef logic [1:0] bidx_type;

   localparam bidx_type IDX_FIRST  = 2'd0;
   localparam bidx_type IDX_SECOND = 2'd1;
   localparam bidx_type IDX_THIRD  = 2'd2;
   localparam bidx_type IDX_FOURTH = 2'd3;

   // One queued work packet: up to two code points, plus the end-of-text flag.
   // With no code point at all it stands for a bare end marker.
   typedef struct packed {
      logic     a_valid;
      cp_type   a_cp;
      bidx_type a_last;
      logic     b_valid;
      cp_type   b_cp;
      bidx_type b_last;
      logic     fin;
   } entry_type;

   function automatic bidx_type last_index(cp_type cp);
      bidx_type r;
      if (cp <= ONE_MAX) begin
         r = IDX_FIRST;
      end else if (cp <= TWO_MAX) begin
         r = IDX_SECOND;
      end else if (cp <= THREE_MAX) begin
         r = IDX_THIRD;
      end else begin
         r = IDX_FOURTH;
      end
      return r;
   endfunction

   function automatic logic [7:0] utf8_byte(cp_type cp, bidx_type last, bidx_type idx);
      logic [7:0] r;
      unique case (last)
         IDX_FIRST: begin
            r = cp[7:0];
         end
         IDX_SECOND: begin
            r = (idx == IDX_FIRST) ? (LEAD2 | {3'b000, cp[10:6]}) : (CONT | {2'b00, cp[5:0]});
         end
         IDX_THIRD: begin
            unique case (idx)
               IDX_FIRST:  r = LEAD3 | {4'b0000, cp[15:12]};
               IDX_SECOND: r = CONT | {2'b00, cp[11:6]};
               default:    r = CONT | {2'b00, cp[5:0]};
            endcase
         end
         default: begin
            unique case (idx)
               IDX_FIRST:  r = LEAD4 | {5'b00000, cp[20:18]};
               IDX_SECOND: r = CONT | {2'b00, cp[17:12]};
               IDX_THIRD:  r = CONT | {2'b00, cp[11:6]};
               default:    r = CONT | {2'b00, cp[5:0]};
            endcase
         end
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/u16u8_if.sv -----
// Valid/ready channel interfaces for the transcoder's byte input and UTF-8 output.
// No dependencies.
interface u16u8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u16u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       text_end;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output text_end, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input run_last,
                 input text_end, output ready);
endinterface

// ----- rtl/u16u8_front.sv -----
// Front end: pairs input bytes into UTF-16 units, tracks surrogates and the byte-order mark,
// and turns accepted bytes into queue packets of code points. Uses u16u8_pkg, u16u8_req_if.
module u16u8_front (
   input  logic                  clock,
   input  logic                  reset,
   u16u8_req_if.sink             req,
   input  logic                  queue_full,
   output logic                  push,
   output u16u8_pkg::entry_type  push_data
);
   import u16u8_pkg::*;

   logic [7:0] held_low_ff, held_low_in;
   logic       phase_ff, phase_in;
   logic [9:0] pend_bits_ff, pend_bits_in;
   logic       pend_valid_ff, pend_valid_in;
   logic       start_ff, start_in;

   logic       accept;
   logic [15:0] unit;
   logic       is_bom, is_low, is_high;
   cp_type     flush_cp, combined_cp;
   logic       x_valid, y_valid;
   cp_type     x_cp, y_cp;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;

   assign unit        = {req.data_byte, held_low_ff};
   assign is_bom      = start_ff && (unit == BOM_UNIT);
   assign is_low      = (unit >= SUR_LOW_MIN) && (unit <= SUR_LOW_MAX);
   assign is_high     = (unit >= SUR_HIGH_MIN) && (unit <= SUR_HIGH_MAX);
   assign flush_cp    = {5'b00000, SUR_HIGH_TAG, pend_bits_ff};
   assign combined_cp = SUPP_BASE + {1'b0, pend_bits_ff, unit[9:0]};

   always_comb begin
      x_valid       = 1'b0;
      x_cp          = flush_cp;
      y_valid       = 1'b0;
      y_cp          = {5'b00000, unit};
      held_low_in   = held_low_ff;
      phase_in      = phase_ff;
      pend_bits_in  = pend_bits_ff;
      pend_valid_in = pend_valid_ff;
      start_in      = start_ff;

      if (!phase_ff) begin
         held_low_in = req.data_byte;
         phase_in    = 1'b1;
         // A high surrogate still held at the end of a text goes out on its own.
         if (req.final_byte) begin
            x_valid = pend_valid_ff;
         end
      end else begin
         phase_in = 1'b0;
         start_in = 1'b0;
         priority if (is_bom) begin
            // Leading byte-order mark: dropped silently.
         end else if (pend_valid_ff && is_low) begin
            x_valid       = 1'b1;
            x_cp          = combined_cp;
            pend_valid_in = 1'b0;
            pend_bits_in  = '0;
         end else begin
            x_valid = pend_valid_ff;
            if (is_high) begin
               pend_valid_in = 1'b1;
               pend_bits_in  = unit[9:0];
               // At end of text the new high surrogate is flushed as itself.
               y_valid       = req.final_byte;
            end else begin
               pend_valid_in = 1'b0;
               pend_bits_in  = '0;
               y_valid       = 1'b1;
            end
         end
      end

      if (req.final_byte) begin
         phase_in      = 1'b0;
         pend_valid_in = 1'b0;
         pend_bits_in  = '0;
         start_in      = 1'b1;
      end
   end

   always_comb begin
      push_data.fin = req.final_byte;
      if (x_valid) begin
         push_data.a_valid = 1'b1;
         push_data.a_cp    = x_cp;
         push_data.b_valid = y_valid;
         push_data.b_cp    = y_cp;
      end else begin
         push_data.a_valid = y_valid;
         push_data.a_cp    = y_cp;
         push_data.b_valid = 1'b0;
         push_data.b_cp    = y_cp;
      end
      push_data.a_last = last_index(push_data.a_cp);
      push_data.b_last = last_index(push_data.b_cp);
   end

   assign push = accept && (x_valid || y_valid || req.final_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_bits_ff  <= '0;
         start_ff      <= 1'b1;
         held_low_ff   <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         pend_valid_ff <= pend_valid_in;
         pend_bits_ff  <= pend_bits_in;
         start_ff      <= start_in;
         held_low_ff   <= held_low_in;
      end
   end

endmodule

// ----- rtl/u16u8_queue.sv -----
// Short register queue of code-point packets between the front end and the byte serializer.
// Uses u16u8_pkg for the packet type.
module u16u8_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u16u8_pkg::entry_type  push_data,
   input  logic                  pop,
   output u16u8_pkg::entry_type  head,
   output logic                  full,
   output logic                  empty
);
   import u16u8_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/u16u8_back.sv -----
// Back end: walks the queue head one UTF-8 byte per cycle, while the output is not stalled,
// into a registered output beat. Uses u16u8_pkg and u16u8_rsp_if.
module u16u8_back (
   input  logic                  clock,
   input  logic                  reset,
   input  u16u8_pkg::entry_type  head,
   input  logic                  empty,
   output logic                  pop,
   u16u8_rsp_if.source           rsp
);
   import u16u8_pkg::*;

   logic       sel_ff, sel_in;
   bidx_type   idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       byte_valid_ff, run_last_ff, text_end_ff;

   logic       load, emit;
   cp_type     cur_cp;
   bidx_type   cur_last;
   logic       cp_done, item_done;
   logic [7:0] next_byte;

   assign load      = !rsp_valid_ff || rsp.ready;
   assign emit      = load && !empty;
   assign cur_cp    = sel_ff ? head.b_cp : head.a_cp;
   assign cur_last  = sel_ff ? head.b_last : head.a_last;
   assign cp_done   = (idx_ff == cur_last);
   // A packet without code points is a bare end marker and takes a single beat.
   assign item_done = !head.a_valid || (cp_done && (sel_ff || !head.b_valid));
   assign next_byte = head.a_valid ? utf8_byte(cur_cp, cur_last, idx_ff) : 8'h00;
   assign pop       = emit && item_done;

   always_comb begin
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (item_done) begin
            sel_in = 1'b0;
            idx_in = IDX_FIRST;
         end else if (cp_done) begin
            sel_in = 1'b1;
            idx_in = IDX_FIRST;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 1'b0;
         idx_ff       <= IDX_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff   <= next_byte;
         byte_valid_ff <= head.a_valid;
         run_last_ff   <= item_done;
         text_end_ff   <= item_done && head.fin;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = out_byte_ff;
   assign rsp.byte_valid = byte_valid_ff;
   assign rsp.run_last   = run_last_ff;
   assign rsp.text_end   = text_end_ff;

endmodule

// ----- rtl/utf16le_to_utf8_transcoder_top.sv -----
// UTF-16LE to UTF-8 transcoder. One input byte is accepted per cycle while the packet queue
// has room; the serializer sends one UTF-8 byte per cycle while the output is not stalled,
// and a code point yields 1 to 4 output bytes. A packet made from accepted bytes is written
// into the queue, and the output register loads from the queue head once the output is free.
// Synchronous active-high reset empties the queue and returns to the start-of-text state.
module utf16le_to_utf8_transcoder_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   u16u8_req_if.sink    req,
   u16u8_rsp_if.source  rsp
);
   import u16u8_pkg::*;

   logic      push, pop, full, empty;
   entry_type push_data, head;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   u16u8_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule
